[rtl/bblur_pkg.sv]
// Package for the 3x3 RGB box blur: sizes, beat structs, pipeline structs and register indexes.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bblur_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 768;

    localparam int CH_W     = 8;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 10;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 10;
    localparam int CSUM_W   = 10;
    localparam int SUM_W    = 12;
    localparam int ADDR_W   = $clog2(MAX_WIDTH);

    localparam int MIN_SIZE = 3;

    typedef enum logic [0:0] {
        CFG_ACTIVE_WIDTH  = 1'b0,
        CFG_ACTIVE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic            mode;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_in_beat;

    typedef struct packed {
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [COL_W-1:0] out_column;
        logic [ROW_W-1:0] out_row;
        logic             last_of_frame;
    } t_out_beat;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
    } t_line_word;

    typedef struct packed {
        t_rgb              pix;
        logic [ADDR_W-1:0] col_in;
        logic              top_ok;
        logic              mid_ok;
        logic              wrap;
        logic              emit;
        logic [COL_W-1:0]  out_col;
        logic [ROW_W-1:0]  out_row;
        logic              last;
    } t_stage_a;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             last;
    } t_stage_b;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_col_sum;

endpackage

[rtl/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB box blur: configuration, position counters, input
// stage and line buffer write-back. Uses bblur_pkg, bblur_line_buf, bblur_window, bblur_out.
//
// The block takes one pixel beat per clock in raster order unless the output stalls, and
// gives each blurred pixel one row plus one pixel later in the input stream; after the
// last pixel of a frame, active_width + 1 flush beats (mode 1) push out the rest, and the
// final result carries last_of_frame. Inside, a beat passes three register stages (input
// and line buffer read, window sums, divide by nine), and the result that a beat completes
// is registered in each of them in turn. The line buffer is a single 1024 x 48 bit memory
// with one read and one write per clock, and it needs no clearing after reset. Neighbors
// outside the frame count as zero and the sum is always divided by nine. A configuration
// write restarts the frame and should be made only while the block is idle.
module box_blur_3x3_rgb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bblur_pkg::t_in_beat               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bblur_pkg::t_out_beat              o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  bblur_pkg::t_cfg_idx               i_cfg_index,
    input  logic [bblur_pkg::WIDTH_W-1:0]     i_cfg_data
);

    localparam int WIDTH_W  = bblur_pkg::WIDTH_W;
    localparam int HEIGHT_W = bblur_pkg::HEIGHT_W;
    localparam int COL_W    = bblur_pkg::COL_W;
    localparam int ROW_W    = bblur_pkg::ROW_W;

    logic [WIDTH_W-1:0]  r_act_width;
    logic [HEIGHT_W-1:0] r_act_height;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [HEIGHT_W:0]   h_p1;
    logic [WIDTH_W-1:0]  w_m1;

    logic [COL_W-1:0]    r_in_col, n_in_col;
    logic [ROW_W-1:0]    r_in_row, n_in_row;
    logic [COL_W:0]      col_p1;
    logic                frame_end;

    logic                in_acc, cfg_acc;
    logic                r_a_valid, a_adv, b_ready, c_ready, b_valid;
    bblur_pkg::t_stage_a r_a, n_a;
    bblur_pkg::t_stage_b stage_b;
    bblur_pkg::t_line_word line_rd, line_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_a_valid || b_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign a_adv       = r_a_valid && b_ready;

    always_comb begin
        if (r_act_width < WIDTH_W'(bblur_pkg::MIN_SIZE)) begin
            w_eff = WIDTH_W'(bblur_pkg::MIN_SIZE);
        end else if (r_act_width > WIDTH_W'(bblur_pkg::MAX_WIDTH)) begin
            w_eff = WIDTH_W'(bblur_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_act_width;
        end
        if (r_act_height < HEIGHT_W'(bblur_pkg::MIN_SIZE)) begin
            h_eff = HEIGHT_W'(bblur_pkg::MIN_SIZE);
        end else if (r_act_height > HEIGHT_W'(bblur_pkg::MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(bblur_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_act_height;
        end
        h_p1 = {1'b0, h_eff} + (HEIGHT_W+1)'(1);
        w_m1 = w_eff - WIDTH_W'(1);
    end

    always_comb begin
        frame_end = (r_in_col == '0) && ({1'b0, r_in_row} >= h_p1);
        col_p1    = {1'b0, r_in_col} + (COL_W+1)'(1);
        if (frame_end) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (WIDTH_W'(col_p1) >= w_eff) begin
            n_in_col = '0;
            n_in_row = r_in_row + ROW_W'(1);
        end else begin
            n_in_col = col_p1[COL_W-1:0];
            n_in_row = r_in_row;
        end
    end

    always_comb begin
        if (!i_in_data.mode && (r_in_row < h_eff)) begin
            n_a.pix.red   = i_in_data.in_red;
            n_a.pix.green = i_in_data.in_green;
            n_a.pix.blue  = i_in_data.in_blue;
        end else begin
            n_a.pix = '0;
        end
        n_a.col_in  = r_in_col[bblur_pkg::ADDR_W-1:0];
        n_a.mid_ok  = (r_in_row >= ROW_W'(1)) && (r_in_row <= h_eff);
        n_a.top_ok  = (r_in_row >= ROW_W'(2)) && ({1'b0, r_in_row} <= h_p1);
        n_a.wrap    = (r_in_col == '0) && (r_in_row >= ROW_W'(2));
        n_a.emit    = n_a.wrap || ((r_in_col != '0) && (r_in_row >= ROW_W'(1)));
        n_a.out_col = n_a.wrap ? w_m1[COL_W-1:0] : r_in_col - COL_W'(1);
        n_a.out_row = n_a.wrap ? r_in_row - ROW_W'(2) : r_in_row - ROW_W'(1);
        n_a.last    = n_a.wrap && frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_width  <= WIDTH_W'(800);
            r_act_height <= HEIGHT_W'(600);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_a_valid    <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    bblur_pkg::CFG_ACTIVE_WIDTH: begin
                        r_act_width <= i_cfg_data;
                    end
                    bblur_pkg::CFG_ACTIVE_HEIGHT: begin
                        r_act_height <= i_cfg_data[HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
                r_in_col <= '0;
                r_in_row <= '0;
            end else if (in_acc) begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (b_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a <= n_a;
        end
    end

    // The older row moves up one slot and the new pixel takes its place.
    assign line_wr.top = line_rd.mid;
    assign line_wr.mid = r_a.pix;

    bblur_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_in_col[bblur_pkg::ADDR_W-1:0]),
        .o_rd_data (line_rd),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a.col_in),
        .i_wr_data (line_wr)
    );

    bblur_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_a_valid    (r_a_valid),
        .i_a          (r_a),
        .i_line       (line_rd),
        .i_next_ready (c_ready),
        .o_ready      (b_ready),
        .o_b_valid    (b_valid),
        .o_b          (stage_b)
    );

    bblur_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_b_valid   (b_valid),
        .i_b         (stage_b),
        .i_out_ready (i_out_ready),
        .o_ready     (c_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_in_col} < w_eff))
        else $error("input column counter is outside the active width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_in_row} <= h_p1))
        else $error("input row counter is past the flush row");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output register is empty");

endmodule

[rtl/bblur_line_buf.sv]
// Line buffer of the box blur: one word per column holding the two previous rows.
// One write and one registered read per cycle; uses bblur_pkg.
module bblur_line_buf (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [bblur_pkg::ADDR_W-1:0] i_rd_addr,
    output bblur_pkg::t_line_word       o_rd_data,
    input  logic                        i_wr_en,
    input  logic [bblur_pkg::ADDR_W-1:0] i_wr_addr,
    input  bblur_pkg::t_line_word       i_wr_data
);

    bblur_pkg::t_line_word r_mem [bblur_pkg::MAX_WIDTH];
    bblur_pkg::t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bblur_window.sv]
// Window stage of the box blur: keeps the column sums of the 3x3 window and forms the
// per-channel neighborhood sums. Uses bblur_pkg.
module bblur_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_a_valid,
    input  bblur_pkg::t_stage_a   i_a,
    input  bblur_pkg::t_line_word i_line,
    input  logic                  i_next_ready,
    output logic                  o_ready,
    output logic                  o_b_valid,
    output bblur_pkg::t_stage_b   o_b
);

    function automatic logic [bblur_pkg::CSUM_W-1:0] add3(
        input logic [bblur_pkg::CH_W-1:0] a,
        input logic [bblur_pkg::CH_W-1:0] b,
        input logic [bblur_pkg::CH_W-1:0] c
    );
        return bblur_pkg::CSUM_W'(a) + bblur_pkg::CSUM_W'(b) + bblur_pkg::CSUM_W'(c);
    endfunction

    function automatic logic [bblur_pkg::SUM_W-1:0] sum3(
        input logic [bblur_pkg::CSUM_W-1:0] a,
        input logic [bblur_pkg::CSUM_W-1:0] b,
        input logic [bblur_pkg::CSUM_W-1:0] c
    );
        return bblur_pkg::SUM_W'(a) + bblur_pkg::SUM_W'(b) + bblur_pkg::SUM_W'(c);
    endfunction

    bblur_pkg::t_col_sum r_cs1, r_cs2, n_cs1, n_cs2, new_cs, new_term;
    bblur_pkg::t_rgb     top_m, mid_m;
    bblur_pkg::t_stage_b r_b, n_b;
    logic                r_b_valid;
    logic                adv;

    assign o_ready   = !r_b_valid || i_next_ready;
    assign adv       = i_a_valid && o_ready;
    assign o_b_valid = r_b_valid;
    assign o_b       = r_b;

    always_comb begin
        top_m = i_a.top_ok ? i_line.top : '0;
        mid_m = i_a.mid_ok ? i_line.mid : '0;

        new_cs.red   = add3(top_m.red,   mid_m.red,   i_a.pix.red);
        new_cs.green = add3(top_m.green, mid_m.green, i_a.pix.green);
        new_cs.blue  = add3(top_m.blue,  mid_m.blue,  i_a.pix.blue);

        // At the start of a row the window holds the previous row's right edge,
        // so the new column lies outside the emitted neighborhood.
        new_term = i_a.wrap ? '0 : new_cs;

        n_b.sum_red   = sum3(r_cs1.red,   r_cs2.red,   new_term.red);
        n_b.sum_green = sum3(r_cs1.green, r_cs2.green, new_term.green);
        n_b.sum_blue  = sum3(r_cs1.blue,  r_cs2.blue,  new_term.blue);
        n_b.out_col   = i_a.out_col;
        n_b.out_row   = i_a.out_row;
        n_b.last      = i_a.last;

        n_cs1 = (i_a.col_in == '0) ? '0 : r_cs2;
        n_cs2 = new_cs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_cs1     <= '0;
            r_cs2     <= '0;
        end else if (adv) begin
            r_b_valid <= i_a.emit;
            r_cs1     <= n_cs1;
            r_cs2     <= n_cs2;
        end else if (i_next_ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b <= n_b;
        end
    end

endmodule

[rtl/bblur_out.sv]
// Output stage of the box blur: divides each channel sum by nine and holds the result beat.
// Uses bblur_pkg.
module bblur_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_b_valid,
    input  bblur_pkg::t_stage_b  i_b,
    input  logic                 i_out_ready,
    output logic                 o_ready,
    output logic                 o_out_valid,
    output bblur_pkg::t_out_beat o_out_data
);

    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'((1 << RECIP_SHIFT) / 9 + 1);
    localparam int PROD_W      = bblur_pkg::SUM_W + RECIP_W;

    // Sums stay below 2296, where the rounded-up reciprocal gives the exact floor.
    function automatic logic [bblur_pkg::CH_W-1:0] div9(input logic [bblur_pkg::SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(RECIP_NINE);
        return prod[RECIP_SHIFT +: bblur_pkg::CH_W];
    endfunction

    bblur_pkg::t_out_beat r_out, n_out;
    logic                 r_valid;

    assign o_ready     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_out.out_red       = div9(i_b.sum_red);
        n_out.out_green     = div9(i_b.sum_green);
        n_out.out_blue      = div9(i_b.sum_blue);
        n_out.out_column    = i_b.out_col;
        n_out.out_row       = i_b.out_row;
        n_out.last_of_frame = i_b.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_b_valid) begin
            r_out <= n_out;
        end
    end

endmodule

[tb/sv/tb_box_blur_3x3_rgb.sv]
// Self-checking testbench for the streaming 3x3 RGB box blur: random beats at the power-up
// size, a directed table of beats, clamped sizes, then random frames, checked against an
// in-bench blur predictor. Depends on bblur_pkg and box_blur_3x3_rgb.
module tb_box_blur_3x3_rgb;

    localparam int   CYCLE_LIMIT   = 500000;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   RESET_PROBE   = 805;
    localparam int   RANDOM_BEATS  = 120;
    localparam int   LONG_HOLD     = 300;
    localparam int   FULL_FRAME    = 1 << 30;
    localparam int   DIR_ROWS      = 26;
    localparam logic MODE_PIXEL    = 1'b0;
    localparam logic MODE_FLUSH    = 1'b1;

    typedef struct packed {
        logic                 pinned;
        bblur_pkg::t_in_beat  beat;
        bblur_pkg::t_out_beat want;
    } t_dir_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    bblur_pkg::t_in_beat                 i_in_data;
    logic                                o_out_valid;
    logic                                i_out_ready;
    bblur_pkg::t_out_beat                o_out_data;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    bblur_pkg::t_cfg_idx                 i_cfg_index;
    logic [bblur_pkg::WIDTH_W-1:0]       i_cfg_data;

    bblur_pkg::t_rgb                     row_store [2*bblur_pkg::MAX_WIDTH];
    bblur_pkg::t_rgb                     blur_win [9];
    int                                  next_col;
    int                                  next_row;
    logic [bblur_pkg::WIDTH_W-1:0]       width_reg;
    logic [bblur_pkg::HEIGHT_W-1:0]      height_reg;
    bblur_pkg::t_out_beat                blurred_q [$];
    bblur_pkg::t_out_beat                head_px;
    t_dir_row                            dir_rows [DIR_ROWS];
    int                                  error_count;
    int                                  beats_in;
    int                                  beats_out;
    int                                  frames_done;
    int                                  cfg_writes;
    int                                  cycle_count;
    int                                  hold_request;
    bit                                  no_idle;

    box_blur_3x3_rgb u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int clamped(input int v, input int hi);
        if (v < bblur_pkg::MIN_SIZE) return bblur_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // A wrapped window is read one column to the left, with the column past the edge black.
    function automatic bblur_pkg::t_out_beat blur_at(input bit wrapped, input int col,
                                                     input int row, input bit last);
        int                   sr;
        int                   sg;
        int                   sb;
        bblur_pkg::t_rgb      p;
        bblur_pkg::t_out_beat r;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int k = 0; k < 9; k++) begin
            if (!wrapped) begin
                p = blur_win[k];
            end else if (k % 3 == 2) begin
                p = '0;
            end else begin
                p = blur_win[k+1];
            end
            sr += p.red;
            sg += p.green;
            sb += p.blue;
        end
        r.out_red       = bblur_pkg::CH_W'(sr / 9);
        r.out_green     = bblur_pkg::CH_W'(sg / 9);
        r.out_blue      = bblur_pkg::CH_W'(sb / 9);
        r.out_column    = bblur_pkg::COL_W'(col);
        r.out_row       = bblur_pkg::ROW_W'(row);
        r.last_of_frame = last;
        return r;
    endfunction

    task automatic blur_step(input bblur_pkg::t_in_beat b, output bit got,
                             output bblur_pkg::t_out_beat r);
        int              w;
        int              h;
        int              ic;
        int              ir;
        bblur_pkg::t_rgb pix;
        bblur_pkg::t_rgb top;
        bblur_pkg::t_rgb mid;
        w   = clamped(int'(width_reg), bblur_pkg::MAX_WIDTH);
        h   = clamped(int'(height_reg), bblur_pkg::MAX_HEIGHT);
        ic  = next_col;
        ir  = next_row;
        got = 1'b0;
        r   = '0;
        pix = (b.mode == MODE_PIXEL && ir < h)
              ? bblur_pkg::t_rgb'({b.in_red, b.in_green, b.in_blue}) : '0;
        top = row_store[bblur_pkg::MAX_WIDTH+ic];
        mid = row_store[ic];
        row_store[bblur_pkg::MAX_WIDTH+ic] = mid;
        row_store[ic] = pix;
        if (ir < 2 || ir - 2 >= h) top = '0;
        if (ir < 1 || ir - 1 >= h) mid = '0;
        if (ic == 0) begin
            if (ir >= 2) begin
                got = 1'b1;
                r = blur_at(1'b1, w - 1, ir - 2, ir >= h + 1);
            end
            for (int k = 0; k < 9; k++) blur_win[k] = '0;
        end else begin
            for (int k = 0; k < 9; k += 3) begin
                blur_win[k]   = blur_win[k+1];
                blur_win[k+1] = blur_win[k+2];
            end
        end
        blur_win[2] = top;
        blur_win[5] = mid;
        blur_win[8] = pix;
        if (ic != 0 && ir >= 1) begin
            got = 1'b1;
            r = blur_at(1'b0, ic - 1, ir - 1, 1'b0);
        end
        if (ic == 0 && ir >= h + 1) begin
            next_col = 0;
            next_row = 0;
            frames_done++;
        end else begin
            ic++;
            if (ic >= w) begin
                ic = 0;
                ir++;
            end
            next_col = ic;
            next_row = ir;
        end
    endtask

    function automatic bblur_pkg::t_in_beat in_px(input logic mode, input int red,
                                                  input int green, input int blue);
        bblur_pkg::t_in_beat b;
        b.mode     = mode;
        b.in_red   = bblur_pkg::CH_W'(red);
        b.in_green = bblur_pkg::CH_W'(green);
        b.in_blue  = bblur_pkg::CH_W'(blue);
        return b;
    endfunction

    function automatic bblur_pkg::t_out_beat blur_px(input int level, input int col,
                                                     input int row, input bit last);
        bblur_pkg::t_out_beat r;
        r.out_red       = bblur_pkg::CH_W'(level);
        r.out_green     = bblur_pkg::CH_W'(level);
        r.out_blue      = bblur_pkg::CH_W'(level);
        r.out_column    = bblur_pkg::COL_W'(col);
        r.out_row       = bblur_pkg::ROW_W'(row);
        r.last_of_frame = last;
        return r;
    endfunction

    function automatic bblur_pkg::t_in_beat rand_beat(input logic mode);
        return in_px(mode, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
    endfunction

    task automatic send_beat(input bblur_pkg::t_in_beat b, input bit pinned,
                             input bblur_pkg::t_out_beat pinned_px);
        int                   gap;
        bit                   got;
        bblur_pkg::t_out_beat px;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        blur_step(b, got, px);
        if (got) blurred_q.push_back(pinned ? pinned_px : px);
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (blurred_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input bblur_pkg::t_cfg_idx idx,
                             input logic [bblur_pkg::WIDTH_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == bblur_pkg::CFG_ACTIVE_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val[bblur_pkg::HEIGHT_W-1:0];
        end
        next_col = 0;
        next_row = 0;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_size(input logic [bblur_pkg::WIDTH_W-1:0] w,
                            input logic [bblur_pkg::WIDTH_W-1:0] h);
        settle();
        cfg_write(bblur_pkg::CFG_ACTIVE_WIDTH, w);
        cfg_write(bblur_pkg::CFG_ACTIVE_HEIGHT, h);
    endtask

    task automatic send_frame(input int max_beats, input bit noisy);
        int   w;
        int   h;
        int   len;
        logic mode;
        w   = clamped(int'(width_reg), bblur_pkg::MAX_WIDTH);
        h   = clamped(int'(height_reg), bblur_pkg::MAX_HEIGHT);
        len = w * (h + 1) + 1;
        if (max_beats < len) len = max_beats;
        for (int i = 0; i < len; i++) begin
            mode = (i < w * h) ? MODE_PIXEL : MODE_FLUSH;
            if (noisy && $urandom_range(0, 7) == 0) mode = ~mode;
            send_beat(rand_beat(mode), 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (blurred_q.size() == 0) begin
                $error("blurred beat arrived with nothing expected");
                error_count++;
            end else begin
                head_px = blurred_q.pop_front();
                check_field("out_red", head_px.out_red, o_out_data.out_red);
                check_field("out_green", head_px.out_green, o_out_data.out_green);
                check_field("out_blue", head_px.out_blue, o_out_data.out_blue);
                check_field("out_column", head_px.out_column, o_out_data.out_column);
                check_field("out_row", head_px.out_row, o_out_data.out_row);
                check_field("last_of_frame", head_px.last_of_frame, o_out_data.last_of_frame);
            end
        end
    end

    initial begin : result_sink
        int wait_n;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request > 0) begin
                wait_n = hold_request;
                hold_request = 0;
            end else begin
                wait_n = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (wait_n > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int                            random_start;
        int                            kind;
        bit                            restart_due;
        logic [bblur_pkg::WIDTH_W-1:0] wv;
        logic [bblur_pkg::WIDTH_W-1:0] hv;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = bblur_pkg::CFG_ACTIVE_WIDTH;
        i_cfg_data   = '0;
        width_reg    = 11'd800;
        height_reg   = 10'd600;
        next_col     = 0;
        next_row     = 0;
        error_count  = 0;
        beats_in     = 0;
        beats_out    = 0;
        frames_done  = 0;
        cfg_writes   = 0;
        hold_request = 0;
        no_idle      = 1'b0;
        restart_due  = 1'b0;

        dir_rows[0]  = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[1]  = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[2]  = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[3]  = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[4]  = '{1'b1, in_px(MODE_PIXEL, 255, 255, 255), blur_px(113, 0, 0, 1'b0)};
        dir_rows[5]  = '{1'b1, in_px(MODE_PIXEL, 255, 255, 255), blur_px(170, 1, 0, 1'b0)};
        dir_rows[6]  = '{1'b1, in_px(MODE_PIXEL, 255, 255, 255), blur_px(113, 2, 0, 1'b0)};
        dir_rows[7]  = '{1'b1, in_px(MODE_PIXEL, 255, 255, 255), blur_px(170, 0, 1, 1'b0)};
        dir_rows[8]  = '{1'b1, in_px(MODE_PIXEL, 255, 255, 255), blur_px(255, 1, 1, 1'b0)};
        dir_rows[9]  = '{1'b1, in_px(MODE_FLUSH, 0, 0, 0), blur_px(170, 2, 1, 1'b0)};
        dir_rows[10] = '{1'b1, in_px(MODE_FLUSH, 0, 0, 0), blur_px(113, 0, 2, 1'b0)};
        dir_rows[11] = '{1'b1, in_px(MODE_FLUSH, 0, 0, 0), blur_px(170, 1, 2, 1'b0)};
        dir_rows[12] = '{1'b1, in_px(MODE_FLUSH, 0, 0, 0), blur_px(113, 2, 2, 1'b1)};
        dir_rows[13] = '{1'b0, in_px(MODE_PIXEL, 0, 0, 0), '0};
        dir_rows[14] = '{1'b0, in_px(MODE_PIXEL, 255, 0, 255), '0};
        dir_rows[15] = '{1'b0, in_px(MODE_PIXEL, 0, 255, 0), '0};
        dir_rows[16] = '{1'b0, in_px(MODE_FLUSH, 255, 255, 255), '0};
        dir_rows[17] = '{1'b0, in_px(MODE_PIXEL, 128, 64, 32), '0};
        dir_rows[18] = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[19] = '{1'b0, in_px(MODE_PIXEL, 1, 2, 3), '0};
        dir_rows[20] = '{1'b0, in_px(MODE_PIXEL, 254, 127, 0), '0};
        dir_rows[21] = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[22] = '{1'b0, in_px(MODE_FLUSH, 0, 0, 0), '0};
        dir_rows[23] = '{1'b0, in_px(MODE_PIXEL, 255, 255, 255), '0};
        dir_rows[24] = '{1'b0, in_px(MODE_FLUSH, 0, 0, 0), '0};
        dir_rows[25] = '{1'b0, in_px(MODE_FLUSH, 0, 0, 0), '0};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A little over one row at the power-up size, then a restart by register writes.
        for (int i = 0; i < RESET_PROBE; i++) send_beat(rand_beat(MODE_PIXEL), 1'b0, '0);
        set_size(11'd3, 11'd3);
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);
        end

        // Width clamps up from zero; the height write loses its top bit and clamps up.
        set_size(11'd0, 11'h400);
        hold_request = LONG_HOLD;
        send_frame(FULL_FRAME, 1'b0);
        set_size(11'd5, 11'd4);
        no_idle = 1'b1;
        send_frame(FULL_FRAME, 1'b0);
        no_idle = 1'b0;

        random_start = beats_in;
        while (beats_in - random_start < RANDOM_BEATS) begin
            if (restart_due || $urandom_range(0, 3) == 0) begin
                wv = bblur_pkg::WIDTH_W'($urandom_range(0, 16));
                hv = bblur_pkg::WIDTH_W'($urandom_range(0, 10));
                if ($urandom_range(0, 4) == 0) hv = hv | 11'h400;
                set_size(wv, hv);
                restart_due = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                settle();
            end
            no_idle = ($urandom_range(0, 4) == 0);
            if (beats_in - random_start < 40) hold_request = LONG_HOLD;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_frame(FULL_FRAME, 1'b0);
            end else if (kind < 9) begin
                send_frame(FULL_FRAME, 1'b1);
            end else begin
                send_frame($urandom_range(1, 60), 1'b1);
                restart_due = 1'b1;
            end
        end
        no_idle = 1'b0;

        i_in_valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Blur run: %0d beats in, %0d blurred beats checked, %0d frames closed.",
                 beats_in, beats_out, frames_done);
        $display("Power-up size, clamped and small random frames, stalls, %0d register writes.",
                 cfg_writes);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bblur_pkg.sv
rtl/bblur_line_buf.sv
rtl/bblur_window.sv
rtl/bblur_out.sv
rtl/box_blur_3x3_rgb.sv
tb/sv/tb_box_blur_3x3_rgb.sv
